@@ hw/rtl/nvs_pkg.sv @@
// Shared types, widths and codes for the nearest vertex search core.
package nvs_pkg;

    // Field widths
    localparam int COORD_W     = 20;
    localparam int INDEX_W     = 12;
    localparam int COUNT_W     = 13;
    localparam int TDATA_IN_W  = 72;
    localparam int TDATA_OUT_W = 16;
    localparam int VERTEX_W    = 3 * COORD_W;

    // Distance arithmetic: difference magnitude, per-axis square, sum of three
    localparam int MAG_W  = COORD_W + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int DIST_W = SQ_W + 2;

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Default store depth
    localparam int MAX_VERTICES_DEF = 4096;

    // Request kind carried in tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Command kind after classification
    typedef enum logic [1:0] {
        K_LOAD,
        K_QUERY,
        K_SKIP
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [INDEX_W-1:0]         index;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } t_cmd;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_queue_head;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } t_front_status;

    typedef struct packed {
        logic scanning;
        logic result_load;
    } t_back_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_back_state;

endpackage

@@ hw/rtl/nvs_front.sv @@
// Front end: accepts requests, classifies them and queues them for the back end.
module nvs_front #(
    parameter int MAX_VERTICES = nvs_pkg::MAX_VERTICES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // vertex_index[11:0], coord_x[31:12], coord_y[51:32], coord_z[71:52]
    input  logic [nvs_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
    // req_type[0]
    input  logic [0:0]                       s_axis_tuser,
    output nvs_pkg::t_queue_head             o_head,
    input  logic                             i_pop,
    output nvs_pkg::t_front_status           o_status
);

    nvs_pkg::t_cmd                  r_q_mem [nvs_pkg::QUEUE_DEPTH];
    logic [nvs_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [nvs_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [nvs_pkg::QCNT_W-1:0]     r_count, n_count;
    nvs_pkg::t_cmd                  w_cmd;
    logic                           w_push;

    // Unpack and classify the incoming request
    always_comb begin
        w_cmd.index = s_axis_tdata[nvs_pkg::INDEX_W-1:0];
        w_cmd.x     = s_axis_tdata[nvs_pkg::INDEX_W +: nvs_pkg::COORD_W];
        w_cmd.y     = s_axis_tdata[nvs_pkg::INDEX_W + nvs_pkg::COORD_W +: nvs_pkg::COORD_W];
        w_cmd.z     = s_axis_tdata[nvs_pkg::INDEX_W + 2 * nvs_pkg::COORD_W +: nvs_pkg::COORD_W];
        if (s_axis_tuser[0] == nvs_pkg::REQ_QUERY) begin
            w_cmd.kind = nvs_pkg::K_QUERY;
        end else if (32'(w_cmd.index) < 32'(MAX_VERTICES)) begin
            w_cmd.kind = nvs_pkg::K_LOAD;
        end else begin
            // drop loads beyond the store
            w_cmd.kind = nvs_pkg::K_SKIP;
        end
    end

    assign s_axis_tready = (r_count < nvs_pkg::QCNT_W'(nvs_pkg::QUEUE_DEPTH));
    assign w_push        = s_axis_tvalid & s_axis_tready;

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == nvs_pkg::QPTR_W'(nvs_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == nvs_pkg::QPTR_W'(nvs_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the request payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_mem[r_wr_ptr] <= w_cmd;
        end
    end

    assign o_head.valid    = (r_count != '0);
    assign o_head.cmd      = r_q_mem[r_rd_ptr];
    assign o_status.count  = r_count;

endmodule

@@ hw/rtl/nvs_back.sv @@
// Back end: vertex store, distance scan pipeline and result register.
module nvs_back #(
    parameter int MAX_VERTICES = nvs_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  nvs_pkg::t_queue_head              i_head,
    output logic                              o_pop,
    input  logic [nvs_pkg::COUNT_W-1:0]       i_vertex_count,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // nearest_index[11:0], zero fill[15:12]
    output logic [nvs_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    output nvs_pkg::t_back_status             o_status
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    // Magnitude of the difference of two coordinates
    function automatic logic [nvs_pkg::MAG_W-1:0] abs_diff(
        input logic [nvs_pkg::COORD_W-1:0] a,
        input logic [nvs_pkg::COORD_W-1:0] b
    );
        logic [nvs_pkg::MAG_W:0] d;
        logic [nvs_pkg::MAG_W:0] m;
        d = {{2{a[nvs_pkg::COORD_W-1]}}, a} - {{2{b[nvs_pkg::COORD_W-1]}}, b};
        m = d[nvs_pkg::MAG_W] ? (~d + 1'b1) : d;
        return m[nvs_pkg::MAG_W-1:0];
    endfunction

    logic [nvs_pkg::VERTEX_W-1:0]     r_mem [MAX_VERTICES];

    nvs_pkg::t_back_state             r_state, n_state;
    logic [CW-1:0]                    r_addr;
    logic [CW-1:0]                    r_n;
    logic [CW-1:0]                    w_n_clamp;
    logic signed [nvs_pkg::COORD_W-1:0] r_qx, r_qy, r_qz;

    // Scan pipeline
    logic [nvs_pkg::VERTEX_W-1:0]     r_rd_data;
    logic                             r_v1, r_v2, r_v3;
    logic [AW-1:0]                    r_i1, r_i2, r_i3;
    logic [nvs_pkg::SQ_W-1:0]         r_sqx, r_sqy, r_sqz;
    logic [nvs_pkg::DIST_W-1:0]       r_dist;
    logic                             r_have;
    logic [nvs_pkg::DIST_W-1:0]       r_best_dist;
    logic [AW-1:0]                    r_best_idx;

    // Result register
    logic                             r_out_valid;
    logic [nvs_pkg::INDEX_W-1:0]      r_out_index;

    logic                             w_issue, w_we, w_start, w_result_load;
    logic [AW+nvs_pkg::INDEX_W-1:0]   w_waddr_ext;
    logic [AW+nvs_pkg::INDEX_W-1:0]   w_best_ext;
    logic [nvs_pkg::MAG_W-1:0]        w_mx, w_my, w_mz;

    assign w_n_clamp   = (32'(i_vertex_count) > 32'(MAX_VERTICES))
                         ? CW'(MAX_VERTICES) : CW'(i_vertex_count);
    assign w_waddr_ext = {{AW{1'b0}}, i_head.cmd.index};
    assign w_best_ext  = {{nvs_pkg::INDEX_W{1'b0}}, r_best_idx};
    assign w_issue     = (r_state == nvs_pkg::S_SCAN) && (r_addr < r_n);

    // Next state and control
    always_comb begin
        n_state       = r_state;
        o_pop         = 1'b0;
        w_we          = 1'b0;
        w_start       = 1'b0;
        w_result_load = 1'b0;
        unique case (r_state)
            nvs_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.cmd.kind)
                        nvs_pkg::K_LOAD: begin
                            w_we = 1'b1;
                        end
                        nvs_pkg::K_QUERY: begin
                            w_start = 1'b1;
                            n_state = nvs_pkg::S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            nvs_pkg::S_SCAN: begin
                if (!w_issue && !r_v1 && !r_v2 && !r_v3) begin
                    n_state = nvs_pkg::S_DONE;
                end
            end
            nvs_pkg::S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_result_load = 1'b1;
                    n_state       = nvs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nvs_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nvs_pkg::S_IDLE;
            r_addr      <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= w_issue;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            if (w_start) begin
                r_addr <= '0;
                r_have <= 1'b0;
            end else begin
                if (w_issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_v3) begin
                    r_have <= 1'b1;
                end
            end
            if (w_result_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Write the store on a load
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr_ext[AW-1:0]] <= {i_head.cmd.x, i_head.cmd.y, i_head.cmd.z};
        end
    end

    // Read the store during a scan
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
    end

    assign w_mx = abs_diff(r_rd_data[2*nvs_pkg::COORD_W +: nvs_pkg::COORD_W], r_qx);
    assign w_my = abs_diff(r_rd_data[nvs_pkg::COORD_W +: nvs_pkg::COORD_W], r_qy);
    assign w_mz = abs_diff(r_rd_data[0 +: nvs_pkg::COORD_W], r_qz);

    // Latch the query, square, sum and keep the running minimum
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_qx       <= i_head.cmd.x;
            r_qy       <= i_head.cmd.y;
            r_qz       <= i_head.cmd.z;
            r_n        <= w_n_clamp;
            r_best_idx <= '0;
        end else if (r_v3 && (!r_have || (r_dist < r_best_dist))) begin
            r_best_dist <= r_dist;
            r_best_idx  <= r_i3;
        end
        r_i1   <= r_addr[AW-1:0];
        r_i2   <= r_i1;
        r_i3   <= r_i2;
        r_sqx  <= w_mx * w_mx;
        r_sqy  <= w_my * w_my;
        r_sqz  <= w_mz * w_mz;
        r_dist <= nvs_pkg::DIST_W'(r_sqx) + nvs_pkg::DIST_W'(r_sqy)
                  + nvs_pkg::DIST_W'(r_sqz);
        if (w_result_load) begin
            r_out_index <= w_best_ext[nvs_pkg::INDEX_W-1:0];
        end
    end

    assign m_axis_tvalid        = r_out_valid;
    assign m_axis_tdata         = {{(nvs_pkg::TDATA_OUT_W - nvs_pkg::INDEX_W){1'b0}}, r_out_index};
    assign o_status.scanning    = (r_state == nvs_pkg::S_SCAN);
    assign o_status.result_load = w_result_load;

endmodule

@@ hw/rtl/nearest_vertex_search_core.sv @@
// Top level of the nearest vertex search core: config register, front, back.
//
// Use: load vertices with s_axis requests of kind load (tuser = 0), carrying
// the store slot and x, y, z in micrometres; set the search count through the
// cfg channel; then send query requests (tuser = 1) with a sensor position.
// Each query returns one m_axis item holding the index of the closest vertex
// among the first vertex_count slots, lowest index on ties, 0 with no
// vertices. Loads return nothing; loads to slots past the store are dropped.
// Requests enter a four-entry queue, so s_axis keeps accepting while the
// back end scans or a result waits on m_axis.
// A load writes the store as it leaves the queue; a query over n slots,
// n = min(vertex_count, MAX_VERTICES), is scanned through the single store
// read port that feeds one vertex per cycle into a three-stage pipeline,
// and its result then goes to the result register. The back end takes no
// further request until that result is loaded.
// Reset clears the queue, the result valid flag and vertex_count; store
// contents stay undefined until loaded. A stalled m_axis holds the result,
// the back end waits with the next finished query, and the queue fills
// until s_axis_tready drops.
module nearest_vertex_search_core #(
    parameter int MAX_VERTICES = nvs_pkg::MAX_VERTICES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // vertex_index[11:0], coord_x[31:12], coord_y[51:32], coord_z[71:52]
    input  logic [nvs_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
    // req_type[0]
    input  logic [0:0]                        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // nearest_index[11:0], zero fill[15:12]
    output logic [nvs_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nvs_pkg::COUNT_W-1:0]       i_cfg_data
);

    logic [nvs_pkg::COUNT_W-1:0]  r_vertex_count;
    nvs_pkg::t_queue_head         w_head;
    nvs_pkg::t_front_status       w_fst;
    nvs_pkg::t_back_status        w_bst;
    logic                         w_pop;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    nvs_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_head        (w_head),
        .i_pop         (w_pop),
        .o_status      (w_fst)
    );

    nvs_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .i_vertex_count (r_vertex_count),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .o_status       (w_bst)
    );

    // A new result appears only after the back end finished a query
    a_result_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_bst.result_load))
        else $error("result appeared without a finished query");

    // The back end never takes a request from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("request taken from empty queue");

    // No request is taken while a scan is in progress
    a_no_pop_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bst.scanning |-> !w_pop)
        else $error("request taken during scan");

    // Queue occupancy stays within its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fst.count <= nvs_pkg::QCNT_W'(nvs_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

endmodule
